// File: rtl/core/dual_path_arx_hash_512_macros.svh
// Assertion macros for the hash engine checker.
`ifndef DUAL_PATH_ARX_HASH_512_MACROS_SVH
`define DUAL_PATH_ARX_HASH_512_MACROS_SVH
// Check that a condition implies a consequence in the next cycle.
`define DPAH_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define DPAH_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/dpah_pkg.sv
// Shared types, constants and round functions of the hash engine.
`timescale 1ns / 1ps
package dpah_pkg;
  localparam int RoundCount = 64;
  localparam int RoundW = $clog2(RoundCount);
  localparam logic [10:0] TailLimit = 11'd768;

  typedef struct packed {
    logic [63:0] msg_word;
    logic [6:0]  bits_valid;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        digest_last;
  } out_item_t;

  // Front-to-back job: one masked word with its bookkeeping.
  typedef struct packed {
    logic [63:0] word;
    logic [6:0]  bits;
    logic        last;
  } job_t;

  typedef struct packed {
    logic [15:0][63:0] m;
    logic [3:0][63:0]  b;
    logic [63:0]       c0;
    logic [63:0]       c1;
    logic [3:0][63:0]  s;
  } enc_state_t;

  localparam logic [3:0][63:0] IvTop = {64'ha1513c69681ad6d4, 64'h70b7ed67fc9b5c42,
                                        64'h5815a7be0543c11c, 64'h0cc4a61194f81760};
  localparam logic [3:0][63:0] IvBot = {64'hca320b75e2b634f9, 64'hb467369e08efd70e,
                                        64'h720dcdfd9dba5b44, 64'h44f9363580e83d02};

  function automatic logic [63:0] rc(input logic [5:0] i);
    logic [63:0] r;
    begin
      unique case (i)
        6'd0: r = 64'h243f6a8885a308d3;  6'd1: r = 64'h13198a2e03707344;
        6'd2: r = 64'ha4093822299f31d0;  6'd3: r = 64'h082efa98ec4e6c89;
        6'd4: r = 64'h452821e638d01377;  6'd5: r = 64'hbe5466cf34e90c6c;
        6'd6: r = 64'hc0ac29b7c97c50dd;  6'd7: r = 64'h3f84d5b5b5470917;
        6'd8: r = 64'h9216d5d98979fb1b;  6'd9: r = 64'hd1310ba698dfb5ac;
        6'd10: r = 64'h2ffd72dbd01adfb7; 6'd11: r = 64'hb8e1afed6a267e96;
        6'd12: r = 64'hba7c9045f12c7f99; 6'd13: r = 64'h24a19947b3916cf7;
        6'd14: r = 64'h0801f2e2858efc16; 6'd15: r = 64'h636920d871574e69;
        6'd16: r = 64'ha458fea3f4933d7e; 6'd17: r = 64'h0d95748f728eb658;
        6'd18: r = 64'h718bcd5882154aee; 6'd19: r = 64'h7b54a41dc25a59b5;
        6'd20: r = 64'h9c30d5392af26013; 6'd21: r = 64'hc5d1b023286085f0;
        6'd22: r = 64'hca417918b8db38ef; 6'd23: r = 64'h8e79dcb0603a180e;
        6'd24: r = 64'h6c9e0e8bb01e8a3e; 6'd25: r = 64'hd71577c1bd314b27;
        6'd26: r = 64'h78af2fda55605c60; 6'd27: r = 64'he65525f3aa55ab94;
        6'd28: r = 64'h5748986263e81440; 6'd29: r = 64'h55ca396a2aab10b6;
        6'd30: r = 64'hb4cc5c341141e8ce; 6'd31: r = 64'ha15486af7c72e993;
        6'd32: r = 64'hb3ee1411636fbc2a; 6'd33: r = 64'h2ba9c55d741831f6;
        6'd34: r = 64'hce5c3e169b87931e; 6'd35: r = 64'hafd6ba336c24cf5c;
        6'd36: r = 64'h7a32538128958677; 6'd37: r = 64'h3b8f48986b4bb9af;
        6'd38: r = 64'hc4bfe81b66282193; 6'd39: r = 64'h61d809ccfb21a991;
        6'd40: r = 64'h487cac605dec8032; 6'd41: r = 64'hef845d5de98575b1;
        6'd42: r = 64'hdc262302eb651b88; 6'd43: r = 64'h23893e81d396acc5;
        6'd44: r = 64'h0f6d6ff383f44239; 6'd45: r = 64'h2e0b4482a4842004;
        6'd46: r = 64'h69c8f04a9e1f9b5e; 6'd47: r = 64'h21c66842f6e96c9a;
        6'd48: r = 64'h670c9c61abd388f0; 6'd49: r = 64'h6a51a0d2d8542f68;
        6'd50: r = 64'h960fa728ab5133a3; 6'd51: r = 64'h6eef0b6c137a3be4;
        6'd52: r = 64'hba3bf0507efb2a98; 6'd53: r = 64'ha1f1651d39af0176;
        6'd54: r = 64'h66ca593e82430e88; 6'd55: r = 64'h8cee8619456f9fb4;
        6'd56: r = 64'h7d84a5c33b8b5ebe; 6'd57: r = 64'he06f75d885c12073;
        6'd58: r = 64'h401a449f56c16aa6; 6'd59: r = 64'h4ed3aa62363f7706;
        6'd60: r = 64'h1bfedf72429b023d; 6'd61: r = 64'h37d0d724d00a1248;
        6'd62: r = 64'hdb0fead349f1c09b; 6'd63: r = 64'h075372c980991b7b;
        default: r = 64'h0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [63:0] rol(input logic [63:0] x, input int n);
    return (n == 0) ? x : ((x << n) | (x >> (64 - n)));
  endfunction

  // One round of the 256-bit ARX cipher with its key schedule.
  function automatic enc_state_t enc_round(input enc_state_t st, input logic [RoundW-1:0] r);
    enc_state_t o;
    logic [63:0] k0, k1, k2, k3, x0, x1, x2, x3, tt, t1, t2;
    begin
      k0 = st.m[0] ^ st.b[0] ^ st.c0;
      k1 = st.m[1] ^ st.b[1] ^ st.c1;
      k2 = st.m[8] ^ st.b[2];
      k3 = st.m[9] ^ st.b[3];
      x0 = st.s[0] ^ k0 ^ rc(6'(r));
      x1 = st.s[1] ^ k1;
      x2 = st.s[2];
      x3 = st.s[3];
      tt = x2 ^ x3;
      o.s[0] = x2;
      o.s[1] = x3;
      o.s[2] = rol(x0, 7) + rol(tt ^ k3, 20);
      o.s[3] = rol(x1, 31) + rol(tt ^ k2, 56);
      t1 = st.m[10] ^ st.m[11];
      t2 = st.m[2] ^ st.m[3];
      o.m[0] = st.m[6];
      o.m[1] = st.m[7];
      o.m[2] = rol(st.m[8], 29) + rol(t1, 6);
      o.m[3] = rol(st.m[9], 63) + rol(t1, 12);
      o.m[4] = st.m[10]; o.m[5] = st.m[11]; o.m[6] = st.m[12]; o.m[7] = st.m[13];
      o.m[8] = st.m[14]; o.m[9] = st.m[15];
      o.m[10] = rol(st.m[0], 14) + rol(t2, 19);
      o.m[11] = rol(st.m[1], 43) + rol(t2, 28);
      o.m[12] = st.m[2]; o.m[13] = st.m[3]; o.m[14] = st.m[4]; o.m[15] = st.m[5];
      o.b[0] = st.b[1];
      o.b[1] = st.b[2];
      o.b[2] = st.b[3];
      o.b[3] = rol(st.b[0], 27) ^ st.b[1];
      o.c0 = st.c1;
      o.c1 = rol(st.c0, 2);
      return o;
    end
  endfunction
endpackage

// File: rtl/core/dpah_front.sv
// Front end: masks incoming words and queues them as jobs for the core.
`timescale 1ns / 1ps
module dpah_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  dpah_pkg::in_item_t in_item,
  output logic              job_valid,
  input  logic              job_take,
  output dpah_pkg::job_t    job
);
  dpah_pkg::job_t q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  dpah_pkg::job_t nj;
  logic [6:0] bv;

  always_comb begin
    bv = (!in_item.last || in_item.bits_valid > 7'd64) ? 7'd64 : in_item.bits_valid;
    nj.bits = bv;
    nj.last = in_item.last;
    // keep the leading bv bits
    nj.word = (bv == 7'd0) ? 64'h0 : (in_item.msg_word & ~({64{1'b1}} >> bv));
  end

  assign full = (cnt == 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign job = q[rp];

  always_ff @(posedge clk) begin
    if (push && !full) q[wp] <= nj;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (job_take && job_valid) rp <= ~rp;
      cnt <= cnt + 2'(push && !full) - 2'(job_take && job_valid);
    end
  end
endmodule

// File: rtl/core/dpah_back.sv
// Back end: block buffer, chains, dual-path compression and digest output.
`timescale 1ns / 1ps
module dpah_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_take,
  input  dpah_pkg::job_t     job,
  output logic               empty,
  input  logic               pop,
  output dpah_pkg::out_item_t out_item
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_COMP = 5'b00010, S_FIN = 5'b00100,
    S_DIG = 5'b01000, S_OUT = 5'b10000
  } st_t;
  st_t state;

  logic [15:0][63:0] buf_w;
  logic [3:0][63:0]  top, bot;
  logic [63:0]       blen;
  logic [3:0]        widx;
  logic              fin;
  logic [dpah_pkg::RoundW-1:0] rnd;
  dpah_pkg::enc_state_t ea, eb, na, nb;
  logic [3:0][63:0]  dig_a, dig_b;
  logic [2:0]        oidx;
  logic [3:0]        wi1;
  logic [10:0]       tail;
  logic [63:0]       blen_n;
  logic [15:0][63:0] buf_n;

  assign na = dpah_pkg::enc_round(ea, rnd);
  assign nb = dpah_pkg::enc_round(eb, rnd);
  assign job_take = (state == S_IDLE) && job_valid;
  assign empty = (state != S_OUT);
  assign out_item.digest_word = oidx[2] ? dig_b[oidx[1:0]] : dig_a[oidx[1:0]];
  assign out_item.digest_last = (oidx == 3'd7);

  always_comb begin
    buf_n = buf_w;
    buf_n[widx] = job.word;
    blen_n = blen + 64'(job.bits);
    wi1 = widx + 4'd1;
    tail = {1'b0, widx, 6'd0} + 11'(job.bits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      buf_w <= '0; top <= dpah_pkg::IvTop; bot <= dpah_pkg::IvBot;
      blen <= '0; widx <= '0; fin <= 1'b0; rnd <= '0; oidx <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (job_valid) begin
          buf_w <= buf_n;
          blen <= blen_n;
          rnd <= '0;
          fin <= job.last;
          if (!job.last) widx <= wi1;
          if ((!job.last && widx == 4'd15) || (job.last && tail > dpah_pkg::TailLimit)) begin
            ea.m <= buf_n; ea.b <= bot; ea.c0 <= '0; ea.c1 <= blen_n; ea.s <= top;
            eb.m <= buf_n; eb.b <= bot; eb.c0 <= '0; eb.c1 <= blen_n;
            eb.s <= {top[3] ^ 64'd1, top[2], top[1], top[0]};
            state <= S_COMP;
          end else if (job.last) begin
            state <= S_FIN;
          end
        end
        S_COMP: begin
          ea <= na; eb <= nb; rnd <= rnd + 1'b1;
          if (rnd == dpah_pkg::RoundW'(dpah_pkg::RoundCount - 1)) begin
            for (int i = 0; i < 4; i++) begin
              top[i] <= na.s[i] ^ top[i];
              bot[i] <= nb.s[i] ^ (i == 3 ? top[3] ^ 64'd1 : top[i]);
            end
            buf_w <= '0;
            widx <= '0;
            state <= fin ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          // key: top chain, bottom chain, then the first twelve tail words
          ea.m <= {buf_w[7:0], bot, top}; ea.b <= buf_w[11:8];
          ea.c0 <= '0; ea.c1 <= blen; ea.s <= {64'd2, 64'd0, 64'd0, 64'd0};
          eb.m <= {buf_w[7:0], bot, top}; eb.b <= buf_w[11:8];
          eb.c0 <= '0; eb.c1 <= blen; eb.s <= {64'd3, 64'd0, 64'd0, 64'd0};
          rnd <= '0;
          state <= S_DIG;
        end
        S_DIG: begin
          ea <= na; eb <= nb; rnd <= rnd + 1'b1;
          if (rnd == dpah_pkg::RoundW'(dpah_pkg::RoundCount - 1)) begin
            dig_a <= na.s; dig_b <= nb.s;
            oidx <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: if (pop) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            buf_w <= '0; top <= dpah_pkg::IvTop; bot <= dpah_pkg::IvBot;
            blen <= '0; widx <= '0; fin <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/dual_path_arx_hash_512.sv
// Top level of the dual-path ARX hash engine.
// Message words enter through a two-entry job queue; a word that does not
// complete a block is absorbed in the idle state, a word that completes a
// block holds the core while the top and bottom paths run their 64 rounds
// side by side, one round per cycle. The last word adds a compression when
// the tail exceeds 768 bits, then the digest encryption, after which eight
// digest words are offered, top path first and lowest word index first.
// Words can be queued while the core runs.
`timescale 1ns / 1ps
module dual_path_arx_hash_512 (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  dpah_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output dpah_pkg::out_item_t out_item
);
  logic           job_valid, job_take;
  dpah_pkg::job_t job;

  dpah_front u_front (
    .clk, .rst, .push, .full, .in_item, .job_valid, .job_take, .job
  );
  dpah_back u_back (
    .clk, .rst, .job_valid, .job_take, .job, .empty, .pop, .out_item
  );
endmodule

// File: rtl/core/dpah_checker.sv
// Port-level checker for the hash engine, bound to the top level.
`timescale 1ns / 1ps
`include "dual_path_arx_hash_512_macros.svh"
module dpah_port_props (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input dpah_pkg::out_item_t out_item
);
  `DPAH_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(out_item))
  `DPAH_ASSERT_NEXT(a_last_ends, clk, rst, !empty && pop && out_item.digest_last, empty)
  `DPAH_ASSERT_NEXT(a_push_out_low, clk, rst, $fell(empty), !out_item.digest_last)
  `DPAH_ASSERT_NEXT(a_full_needs_push, clk, rst, !full && !push, !full)
endmodule

bind dual_path_arx_hash_512 dpah_port_props u_checker (
  .clk, .rst, .push, .full, .empty, .pop, .out_item
);
